// ----- hdl/crbm_pkg.sv -----
// ----------------------------------------------------------------------------
// crbm_pkg
// Types, constants and helpers shared by the counter rate and busy monitor.
// ----------------------------------------------------------------------------
package crbm_pkg;

	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 1;
	localparam int DVD_W     = 74;
	localparam int DVS_W     = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT  = 1'b1;

	localparam logic [15:0] MIN_INTERVAL_RST = 16'd500;
	localparam logic [23:0] STALE_LIMIT_RST  = 24'd30000;

	localparam logic [6:0]  DIV_STEPS    = 7'd74;
	localparam logic [47:0] RATE_MAX     = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] PERMILLE_MAX = 16'hFFFF;
	localparam logic [16:0] FRAC_ONE     = 17'h10000;

	typedef enum logic [1:0] {
		STAT_NODATA = 2'd0,
		STAT_INIT   = 2'd1,
		STAT_STALE  = 2'd2,
		STAT_DATA   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_RD = 2'd0,
		OP_WR = 2'd1,
		OP_PM = 2'd2,
		OP_FR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_START,
		BK_WAIT,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		logic [47:0] now_ms;
		logic        has_data;
		logic [63:0] read_total;
		logic [63:0] write_total;
		logic [47:0] busy_total_ms;
		logic [15:0] disk_count;
	} in_item_t;

	typedef struct packed {
		logic        sampled;
		logic [1:0]  status;
		logic [47:0] read_rate;
		logic [47:0] write_rate;
		logic [15:0] busy_permille;
		logic [16:0] busy_fraction;
		logic [15:0] disks_seen;
	} out_item_t;

	typedef struct packed {
		logic        sampled;
		status_t     status;
		logic        compute;
		logic        rd_pos;
		logic        wr_pos;
		logic        busy_pos;
		logic [63:0] rd_diff;
		logic [63:0] wr_diff;
		logic [47:0] busy_diff;
		logic [47:0] elapsed;
		logic [15:0] disks;
	} job_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [DVD_W-1:0] times_1000(input logic [63:0] x);
		logic [DVD_W-1:0] w;
		w = {10'b0, x};
		return (w << 10) - (w << 4) - (w << 3);
	endfunction

endpackage

// ----- hdl/crbm_in_if.sv -----
// ----------------------------------------------------------------------------
// crbm_in_if
// Sample channel: valid, ready and one counter sample.
// ----------------------------------------------------------------------------
interface crbm_in_if;
	logic               valid;
	logic               ready;
	crbm_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/crbm_out_if.sv -----
// ----------------------------------------------------------------------------
// crbm_out_if
// Result channel: valid, ready and one rate result.
// ----------------------------------------------------------------------------
interface crbm_out_if;
	logic                valid;
	logic                ready;
	crbm_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/counter_rate_and_busy_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// counter_rate_and_busy_monitor_unit
// Per-second read/write rates and busy figures from cumulative counter samples.
// ----------------------------------------------------------------------------
// Channels: sample (sink) takes one timestamped counter sample per transfer;
// result (source) gives exactly one result per sample, in order. Registers
// are written through cfg_we / cfg_idx / cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
// A sample that needs no new rates (ignored, no data, first sample) goes
// from the queue straight to the output register. A sample with data needs
// up to four quotients, run in turn on one bit-serial divider of 74 steps;
// a skipped quotient does not use the divider. The divider sets the throughput.
// A two-entry queue sits between the classifying front and the rate back,
// so samples are taken while earlier ones are being worked on or while a
// result waits; sample.ready drops only when the queue is full.
// A stalled result holds in the output register; no result is dropped.
// Reset clears totals and held results, sets status to init and loads the
// default minimum interval (500 ms) and stale limit (30000 ms).
// ----------------------------------------------------------------------------
module counter_rate_and_busy_monitor_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [crbm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [crbm_pkg::CFG_W-1:0]     cfg_data,
	crbm_in_if.sink                        sample,
	crbm_out_if.source                     result
);

	logic               push;
	logic               full;
	logic               pop;
	logic               not_empty;
	crbm_pkg::job_t     push_job;
	crbm_pkg::job_t     pop_job;
	crbm_pkg::div_req_t div_req;
	crbm_pkg::div_rsp_t div_rsp;

	assign sample.ready = !full;
	assign push         = sample.valid && !full;

	crbm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.push     (push),
		.item     (sample.data),
		.job      (push_job)
	);

	crbm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_job   (pop_job)
	);

	crbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	crbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (not_empty),
		.job_in    (pop_job),
		.pop       (pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.result    (result)
	);

endmodule

// ----- hdl/crbm_front.sv -----
// ----------------------------------------------------------------------------
// crbm_front
// Interval check, status and counter differences; keeps the previous totals.
// ----------------------------------------------------------------------------
module crbm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [crbm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [crbm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                push,
	input  crbm_pkg::in_item_t                  item,
	output crbm_pkg::job_t                      job
);

	logic [15:0]       min_q;
	logic [23:0]       stale_q;
	logic [47:0]       last_q;
	logic [63:0]       prev_rd_q;
	logic [63:0]       prev_wr_q;
	logic [47:0]       prev_busy_q;
	crbm_pkg::status_t status_q;

	logic [47:0]       elapsed;
	logic              take;
	crbm_pkg::status_t new_status;

	always_comb begin
		elapsed = item.now_ms - last_q;
		take    = elapsed > {32'b0, min_q};
		if (!item.has_data) begin
			new_status = crbm_pkg::STAT_NODATA;
		end else if (last_q == '0) begin
			new_status = crbm_pkg::STAT_INIT;
		end else if (elapsed > {24'b0, stale_q}) begin
			new_status = crbm_pkg::STAT_STALE;
		end else begin
			new_status = crbm_pkg::STAT_DATA;
		end
		job.sampled   = take;
		job.status    = take ? new_status : status_q;
		job.compute   = take && item.has_data && (new_status != crbm_pkg::STAT_INIT);
		job.rd_pos    = item.read_total > prev_rd_q;
		job.wr_pos    = item.write_total > prev_wr_q;
		job.busy_pos  = item.busy_total_ms > prev_busy_q;
		job.rd_diff   = item.read_total - prev_rd_q;
		job.wr_diff   = item.write_total - prev_wr_q;
		job.busy_diff = item.busy_total_ms - prev_busy_q;
		job.elapsed   = elapsed;
		job.disks     = item.disk_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= crbm_pkg::MIN_INTERVAL_RST;
			stale_q     <= crbm_pkg::STALE_LIMIT_RST;
			last_q      <= '0;
			prev_rd_q   <= '0;
			prev_wr_q   <= '0;
			prev_busy_q <= '0;
			status_q    <= crbm_pkg::STAT_INIT;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					crbm_pkg::CFG_MIN_INTERVAL: min_q   <= cfg_data[15:0];
					crbm_pkg::CFG_STALE_LIMIT:  stale_q <= cfg_data;
					default: ;
				endcase
			end
			if (push && take) begin
				status_q <= new_status;
				last_q   <= item.now_ms;
				if (item.has_data) begin
					prev_rd_q   <= item.read_total;
					prev_wr_q   <= item.write_total;
					prev_busy_q <= item.busy_total_ms;
				end
			end
		end
	end

endmodule

// ----- hdl/crbm_fifo.sv -----
// ----------------------------------------------------------------------------
// crbm_fifo
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module crbm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  crbm_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output crbm_pkg::job_t pop_job
);

	crbm_pkg::job_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hdl/crbm_div.sv -----
// ----------------------------------------------------------------------------
// crbm_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crbm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  crbm_pkg::div_req_t req,
	output crbm_pkg::div_rsp_t rsp
);

	logic [crbm_pkg::DVD_W-1:0] acc_q;
	logic [crbm_pkg::DVS_W-1:0] rem_q;
	logic [crbm_pkg::DVS_W-1:0] dvs_q;
	logic [6:0]                 cnt_q;
	logic                       done_q;

	logic [crbm_pkg::DVS_W:0]   rem_sh;
	logic [crbm_pkg::DVS_W:0]   rem_sub;
	logic                       fits;

	always_comb begin
		rem_sh  = {rem_q, acc_q[crbm_pkg::DVD_W-1]};
		fits    = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = acc_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != 7'd0) begin
			acc_q <= {acc_q[crbm_pkg::DVD_W-2:0], fits};
			rem_q <= fits ? rem_sub[crbm_pkg::DVS_W-1:0] : rem_sh[crbm_pkg::DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 7'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= crbm_pkg::DIV_STEPS;
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- hdl/crbm_back.sv -----
// ----------------------------------------------------------------------------
// crbm_back
// Rate sequencer: runs the quotients of one job and holds the last results.
// ----------------------------------------------------------------------------
module crbm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	input  crbm_pkg::job_t     job_in,
	output logic               pop,
	output crbm_pkg::div_req_t div_req,
	input  crbm_pkg::div_rsp_t div_rsp,
	crbm_out_if.source         result
);

	crbm_pkg::bk_state_t state_q;
	crbm_pkg::bk_state_t state_d;
	crbm_pkg::op_t       op_q;
	crbm_pkg::job_t      job_q;
	logic [63:0]         den_q;

	logic [47:0]         rd_rate_q;
	logic [47:0]         wr_rate_q;
	logic [15:0]         permille_q;
	logic [16:0]         frac_q;
	logic [15:0]         disks_q;

	logic                out_vld_q;
	crbm_pkg::out_item_t out_q;

	logic                skip;
	logic                frac_ok;
	logic [16:0]         frac_fix;

	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	always_comb begin
		state_d          = state_q;
		pop              = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = {16'b0, job_q.elapsed};
		frac_ok          = job_q.busy_pos && (job_q.disks != 16'd0);
		frac_fix         = frac_ok ? crbm_pkg::FRAC_ONE : 17'd0;
		skip             = 1'b0;
		case (op_q)
			crbm_pkg::OP_RD: begin
				skip             = !job_q.rd_pos;
				div_req.dividend = crbm_pkg::times_1000(job_q.rd_diff);
			end
			crbm_pkg::OP_WR: begin
				skip             = !job_q.wr_pos;
				div_req.dividend = crbm_pkg::times_1000(job_q.wr_diff);
			end
			crbm_pkg::OP_PM: begin
				skip             = !job_q.busy_pos;
				div_req.dividend = crbm_pkg::times_1000({16'b0, job_q.busy_diff});
			end
			crbm_pkg::OP_FR: begin
				skip             = !frac_ok || ({16'b0, job_q.busy_diff} >= den_q);
				div_req.dividend = {10'b0, job_q.busy_diff, 16'b0};
				div_req.divisor  = den_q;
			end
			default: ;
		endcase
		case (state_q)
			crbm_pkg::BK_IDLE: begin
				if (job_valid && !out_vld_q) begin
					pop = 1'b1;
					if (job_in.compute) begin
						state_d = crbm_pkg::BK_MUL;
					end
				end
			end
			crbm_pkg::BK_MUL: state_d = crbm_pkg::BK_START;
			crbm_pkg::BK_START: begin
				if (!skip) begin
					div_req.start = 1'b1;
					state_d       = crbm_pkg::BK_WAIT;
				end else if (op_q == crbm_pkg::OP_FR) begin
					state_d = crbm_pkg::BK_DONE;
				end
			end
			crbm_pkg::BK_WAIT: begin
				if (div_rsp.done) begin
					state_d = (op_q == crbm_pkg::OP_FR) ? crbm_pkg::BK_DONE
						: crbm_pkg::BK_START;
				end
			end
			crbm_pkg::BK_DONE: state_d = crbm_pkg::BK_IDLE;
			default: state_d = crbm_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_in;
		end
		if (state_q == crbm_pkg::BK_MUL) begin
			den_q <= job_q.elapsed * job_q.disks;
		end
		if (pop && !job_in.compute) begin
			out_q.sampled       <= job_in.sampled;
			out_q.status        <= job_in.status;
			out_q.read_rate     <= rd_rate_q;
			out_q.write_rate    <= wr_rate_q;
			out_q.busy_permille <= permille_q;
			out_q.busy_fraction <= frac_q;
			out_q.disks_seen    <= disks_q;
		end else if (state_q == crbm_pkg::BK_DONE) begin
			out_q.sampled       <= job_q.sampled;
			out_q.status        <= job_q.status;
			out_q.read_rate     <= rd_rate_q;
			out_q.write_rate    <= wr_rate_q;
			out_q.busy_permille <= permille_q;
			out_q.busy_fraction <= frac_q;
			out_q.disks_seen    <= disks_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= crbm_pkg::BK_IDLE;
			op_q       <= crbm_pkg::OP_RD;
			out_vld_q  <= 1'b0;
			rd_rate_q  <= '0;
			wr_rate_q  <= '0;
			permille_q <= '0;
			frac_q     <= '0;
			disks_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_vld_q && result.ready) begin
				out_vld_q <= 1'b0;
			end else if ((pop && !job_in.compute) || state_q == crbm_pkg::BK_DONE) begin
				out_vld_q <= 1'b1;
			end
			if (state_q == crbm_pkg::BK_MUL) begin
				op_q    <= crbm_pkg::OP_RD;
				disks_q <= job_q.disks;
			end
			if (state_q == crbm_pkg::BK_START && skip) begin
				case (op_q)
					crbm_pkg::OP_RD: rd_rate_q  <= '0;
					crbm_pkg::OP_WR: wr_rate_q  <= '0;
					crbm_pkg::OP_PM: permille_q <= '0;
					crbm_pkg::OP_FR: frac_q     <= frac_fix;
					default: ;
				endcase
				op_q <= crbm_pkg::op_t'(op_q + 2'd1);
			end
			if (state_q == crbm_pkg::BK_WAIT && div_rsp.done) begin
				case (op_q)
					crbm_pkg::OP_RD: rd_rate_q <= (div_rsp.quotient[73:48] != '0)
						? crbm_pkg::RATE_MAX : div_rsp.quotient[47:0];
					crbm_pkg::OP_WR: wr_rate_q <= (div_rsp.quotient[73:48] != '0)
						? crbm_pkg::RATE_MAX : div_rsp.quotient[47:0];
					crbm_pkg::OP_PM: permille_q <= (div_rsp.quotient[73:16] != '0)
						? crbm_pkg::PERMILLE_MAX : div_rsp.quotient[15:0];
					crbm_pkg::OP_FR: frac_q <= div_rsp.quotient[16:0];
					default: ;
				endcase
				op_q <= crbm_pkg::op_t'(op_q + 2'd1);
			end
		end
	end

endmodule
